[hdl/pbr_pkg.sv]
// Shared constants, codes and controller/datapath command types for the bisection root finder.
package pbr_pkg;

    localparam int FRAC_BITS    = 27;
    localparam int MAX_HALVINGS = 32;
    localparam int DATA_W       = 32;
    localparam int TOL_W        = 31;
    localparam int STEP_W       = 6;
    localparam int HORNER_LAST  = 5;
    localparam int K_W          = 3;

    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

    localparam logic [1:0] SEL_LOWER = 2'd0;
    localparam logic [1:0] SEL_UPPER = 2'd1;
    localparam logic [1:0] SEL_MID   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       eval_init;
        logic [1:0] eval_sel;
        logic       mul;
        logic       acc_upd;
        logic       acc_last;
        logic       save_sl;
        logic       save_sr;
        logic       mark_none;
        logic       set_mid;
        logic       step_inc;
        logic       update_ends;
        logic       set_prev;
        logic       capture;
    } t_dp_cmd;

    typedef struct packed {
        logic no_change;
        logic acc_zero;
        logic prev_match;
        logic more_halvings;
    } t_dp_sts;

endpackage

[hdl/pbr_in_if.sv]
// Input channel: interval ends and tolerance with valid/ready handshake.
interface pbr_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pbr_pkg::DATA_W-1:0]  left_bound;
    logic signed [pbr_pkg::DATA_W-1:0]  right_bound;
    logic        [pbr_pkg::TOL_W-1:0]   tolerance;

    modport source (output valid, output left_bound, output right_bound, output tolerance,
                    input ready);
    modport sink   (input valid, input left_bound, input right_bound, input tolerance,
                    output ready);
endinterface

[hdl/pbr_out_if.sv]
// Output channel: root estimate and status with valid/ready handshake.
interface pbr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pbr_pkg::DATA_W-1:0]  root;
    logic                               status;

    modport source (output valid, output root, output status, input ready);
    modport sink   (input valid, input root, input status, output ready);
endinterface

[hdl/pbr_datapath.sv]
// Datapath: interval registers, shared Horner multiplier, midpoint and width logic, result register.
module pbr_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pbr_pkg::t_dp_cmd                   i_cmd,
    output pbr_pkg::t_dp_sts                   o_sts,
    input  logic signed [pbr_pkg::DATA_W-1:0]  i_left_bound,
    input  logic signed [pbr_pkg::DATA_W-1:0]  i_right_bound,
    input  logic        [pbr_pkg::TOL_W-1:0]   i_tolerance,
    output logic signed [pbr_pkg::DATA_W-1:0]  o_root,
    output logic                               o_status
);
    import pbr_pkg::*;

    logic signed [DATA_W-1:0]   r_lower, r_upper, r_mid, r_prev, r_x, r_acc, r_root;
    logic        [TOL_W-1:0]    r_tol;
    logic signed [2*DATA_W-1:0] r_prod;
    logic        [STEP_W-1:0]   r_step;
    logic                       r_have_prev, r_none, r_status;
    logic                       r_sl_zero, r_sl_neg, r_sr_neg;

    logic signed [2*DATA_W-1:0] w_prod, w_shift, w_sum, w_one_ext;
    logic signed [DATA_W-1:0]   w_sat, w_sel;
    logic signed [DATA_W:0]     w_end_sum, w_diff, w_abs;
    logic signed [DATA_W-1:0]   w_mid;
    logic        [DATA_W-1:0]   w_hw;
    logic                       w_acc_zero;

    assign w_prod    = r_acc * r_x;
    assign w_shift   = r_prod >>> FRAC_BITS;
    assign w_one_ext = (2*DATA_W)'(ONE_FX);
    assign w_sum     = i_cmd.acc_last ? (w_shift - w_one_ext) : (w_shift + w_one_ext);

    always_comb begin
        if (w_sum > $signed(64'h0000_0000_7FFF_FFFF)) begin
            w_sat = $signed(32'h7FFF_FFFF);
        end else if (w_sum < $signed(64'hFFFF_FFFF_8000_0000)) begin
            w_sat = $signed(32'h8000_0000);
        end else begin
            w_sat = w_sum[DATA_W-1:0];
        end
    end

    always_comb begin
        case (i_cmd.eval_sel)
            SEL_LOWER: w_sel = r_lower;
            SEL_UPPER: w_sel = r_upper;
            SEL_MID:   w_sel = r_mid;
            default:   w_sel = r_mid;
        endcase
    end

    assign w_end_sum = {r_lower[DATA_W-1], r_lower} + {r_upper[DATA_W-1], r_upper};
    assign w_mid     = w_end_sum[DATA_W:1];
    assign w_diff    = {r_upper[DATA_W-1], r_upper} - {r_lower[DATA_W-1], r_lower};
    assign w_abs     = w_diff[DATA_W] ? -w_diff : w_diff;
    assign w_hw      = w_abs[DATA_W:1];
    assign w_acc_zero = (r_acc == '0);

    assign o_sts.no_change     = r_sl_zero || w_acc_zero || (r_sl_neg == r_acc[DATA_W-1]);
    assign o_sts.acc_zero      = w_acc_zero;
    assign o_sts.prev_match    = r_have_prev && (r_prev == r_mid);
    assign o_sts.more_halvings = (r_step < STEP_W'(MAX_HALVINGS)) && (w_hw > {1'b0, r_tol});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_have_prev <= 1'b0;
            r_none      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_step      <= '0;
                r_have_prev <= 1'b0;
                r_none      <= 1'b0;
            end
            if (i_cmd.step_inc) r_step <= r_step + 1'b1;
            if (i_cmd.set_prev) r_have_prev <= 1'b1;
            if (i_cmd.mark_none) r_none <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lower <= i_left_bound;
            r_upper <= i_right_bound;
            r_tol   <= i_tolerance;
        end
        if (i_cmd.eval_init) begin
            r_acc <= ONE_FX;
            r_x   <= w_sel;
        end
        if (i_cmd.mul) r_prod <= w_prod;
        if (i_cmd.acc_upd) r_acc <= w_sat;
        if (i_cmd.save_sl) begin
            r_sl_zero <= w_acc_zero;
            r_sl_neg  <= r_acc[DATA_W-1];
        end
        if (i_cmd.save_sr) r_sr_neg <= r_acc[DATA_W-1];
        if (i_cmd.set_mid) r_mid <= w_mid;
        if (i_cmd.update_ends) begin
            if (r_acc[DATA_W-1] == r_sr_neg) begin
                r_upper <= r_mid;
            end else begin
                r_lower <= r_mid;
            end
        end
        if (i_cmd.set_prev) r_prev <= r_mid;
        if (i_cmd.capture) begin
            r_root   <= r_none ? '0 : r_mid;
            r_status <= r_none;
        end
    end

    assign o_root   = r_root;
    assign o_status = r_status;

endmodule

[hdl/pbr_controller.sv]
// Controller: sequences end-point checks, Horner steps and halvings; owns the handshakes.
module pbr_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pbr_pkg::t_dp_cmd o_cmd,
    input  pbr_pkg::t_dp_sts i_sts
);
    import pbr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_TEST = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]     r_state, n_state;
    logic [1:0]     r_phase, n_phase;
    logic [K_W-1:0] r_k, n_k;
    logic           r_out_valid, n_out_valid;
    logic           w_in_fire, w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_k         = r_k;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        o_cmd          = '0;
        o_cmd.eval_sel = r_phase;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_phase    = SEL_LOWER;
                    n_state    = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.eval_init = 1'b1;
                n_k             = '0;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_upd  = 1'b1;
                o_cmd.acc_last = (r_k == K_W'(HORNER_LAST));
                if (r_k == K_W'(HORNER_LAST)) begin
                    n_state = S_EVAL;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_EVAL: begin
                case (r_phase)
                    SEL_LOWER: begin
                        o_cmd.save_sl = 1'b1;
                        n_phase       = SEL_UPPER;
                        n_state       = S_INIT;
                    end
                    SEL_UPPER: begin
                        if (i_sts.no_change) begin
                            o_cmd.mark_none = 1'b1;
                            n_state         = S_OUT;
                        end else begin
                            o_cmd.save_sr = 1'b1;
                            o_cmd.set_mid = 1'b1;
                            n_state       = S_TEST;
                        end
                    end
                    default: begin
                        if (i_sts.acc_zero) begin
                            n_state = S_OUT;
                        end else begin
                            o_cmd.update_ends = 1'b1;
                            if (i_sts.prev_match) begin
                                n_state = S_OUT;
                            end else begin
                                o_cmd.set_prev = 1'b1;
                                n_state        = S_TEST;
                            end
                        end
                    end
                endcase
            end
            S_TEST: begin
                if (i_sts.more_halvings) begin
                    o_cmd.set_mid  = 1'b1;
                    o_cmd.step_inc = 1'b1;
                    n_phase        = SEL_MID;
                    n_state        = S_INIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= SEL_LOWER;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_INIT) && (r_phase == SEL_LOWER))
        else $error("accepted item did not start the lower end evaluation");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_k <= K_W'(HORNER_LAST)))
        else $error("Horner step count out of range");

    a_horner_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) && (r_k == K_W'(HORNER_LAST)) |=> (r_state == S_EVAL))
        else $error("last Horner step did not end the evaluation");

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_out_valid && (r_state == S_IDLE))
        else $error("captured result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> w_out_free)
        else $error("result register overwritten while still pending");

endmodule

[hdl/polynomial_bisection_root.sv]
// Top level of the bisection root finder for x^6+x^5+x^4+x^3+x^2+x-1.
// One item at a time: an accepted interval is checked by evaluating the polynomial at both
// ends, then halved until half its width is not above the tolerance, the midpoint hits an
// exact zero or repeats, or MAX_HALVINGS halvings are done. Each evaluation is an init step,
// six Horner steps of a multiply and an accumulate on the one shared 32x32 multiplier, and an
// evaluation step. The result is registered once the output register is free, and the next
// item can be accepted as soon as the previous result is in the output register, even if it
// has not yet been taken.
module polynomial_bisection_root (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbr_in_if.sink    i_in,
    pbr_out_if.source o_out
);
    import pbr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pbr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pbr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_left_bound  (i_in.left_bound),
        .i_right_bound (i_in.right_bound),
        .i_tolerance   (i_in.tolerance),
        .o_root        (o_out.root),
        .o_status      (o_out.status)
    );

endmodule
